// ===== src/dme_pkg.sv =====
`timescale 1ns / 1ps
package dme_pkg;

  // Sample format and result format
  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = SAMPLE_WIDTH - 1;
  localparam int ACC_W        = 40;
  localparam int LEN_MAX      = 64;
  localparam int LEN_AW       = 6;
  localparam int NORM_W       = 20;
  localparam int NUM_W        = 31;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_FWD  = 2'd1,
    FUNC_ADJ  = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_ZERO  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_LOAD = 2'd1,
    MODE_FWD  = 2'd2,
    MODE_ADJ  = 2'd3
  } mode_t;

  typedef enum logic {
    REG_ATOMS  = 1'b0,
    REG_LENGTH = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_RD,
    ST_SQ_MUL,
    ST_SQ_ADD,
    ST_SQRT,
    ST_CHECK,
    ST_NRM_RD,
    ST_NRM_LD,
    ST_DIV,
    ST_NRM_WR,
    ST_RESULT,
    ST_MAC,
    ST_EMIT
  } state_t;

endpackage

// ===== src/dictionary_matvec_engine.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tdata: atom_index, element_index, sample_value; tuser: func; tlast: last_item
// m_axis    out  tdata: out_index, out_value; tuser: status; tlast: out_last
// cfg       in   cfg_index 0 atoms_in_use, 1 atom_length; cfg_data
//
// One item at a time. The last load element runs a commit: read, multiply and add
// per element for the square sum, the bit-serial root, then per element a read, a
// load and either a copy or the 31-step divider, and a write. A forward or adjoint
// item walks the atom store through a 3-stage read/multiply/accumulate pipe over
// count entries, count being the atom length or the atoms in use. Results leave one
// at a time from the accumulator RAM. Synchronous reset; no clearing pass, the atom
// store holds nothing defined until loaded. A stalled output holds the engine.
module dictionary_matvec_engine #(
  parameter int MAX_ATOMS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // atom_index[4:0], element_index[10:5], sample_value[26:11]
  input  logic [1:0]  s_axis_tuser,   // func
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_index[5:0], out_value[45:6]
  output logic [1:0]  m_axis_tuser,   // status
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  import dme_pkg::*;

  localparam int AW     = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int SDEPTH = MAX_ATOMS * LEN_MAX;
  localparam int SAW    = AW + LEN_AW;
  localparam int NA_MAX = (MAX_ATOMS < 63) ? MAX_ATOMS : 63;

  // configuration registers
  logic [5:0] atoms_in_use;
  logic [6:0] atom_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      atoms_in_use <= 6'd32;
      atom_length  <= 7'd64;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ATOMS:  atoms_in_use <= cfg_data[5:0];
        REG_LENGTH: atom_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [5:0] na;
  logic [6:0] len;
  assign na  = (atoms_in_use == 6'd0) ? 6'd1 :
               (atoms_in_use > 6'(NA_MAX)) ? 6'(NA_MAX) : atoms_in_use;
  assign len = (atom_length == 7'd0) ? 7'd1 :
               (atom_length > 7'(LEN_MAX)) ? 7'(LEN_MAX) : atom_length;

  // input unpacking
  func_t             in_func;
  logic [4:0]        in_ai;
  logic [5:0]        in_ei;
  logic [15:0]       in_s;
  logic              in_acc;
  assign in_func = func_t'(s_axis_tuser);
  assign in_ai   = s_axis_tdata[4:0];
  assign in_ei   = s_axis_tdata[10:5];
  assign in_s    = s_axis_tdata[26:11];
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  // control and datapath registers
  state_t            state, state_next;
  mode_t             run_mode;
  logic              err;
  logic [LEN_MAX-1:0] smask;
  logic [LEN_MAX-1:0] accv;
  logic [4:0]        ai_r;
  logic [5:0]        ei_r;
  logic [15:0]       samp;
  logic              last_r;
  logic              fwd_r;
  logic [6:0]        cnt;
  logic [6:0]        k;
  logic [6:0]        e;
  logic              v1, v2;
  logic [5:0]        k1, k2, ke;
  logic              pend;
  logic signed [31:0] prod;
  logic [31:0]       sq;
  logic [ACC_W-1:0]  sum, sq_rem, root, bit_b;
  logic [NORM_W-1:0] norm;
  logic              do_div;
  logic [NUM_W-1:0]  num, quo;
  logic [NORM_W-1:0] drem;
  logic [4:0]        dcnt;
  logic              neg;
  logic [15:0]       sval;
  logic              oval;
  logic [5:0]        o_index;
  logic [ACC_W-1:0]  o_value;
  logic              o_last;
  status_t           o_status;

  // RAM ports
  logic              stg_we;
  logic [LEN_AW-1:0] stg_raddr;
  logic [15:0]       stg_rdata;
  logic              st_we;
  logic [SAW-1:0]    st_waddr, st_raddr;
  logic [15:0]       st_wdata, st_rdata;
  logic              acc_we;
  logic [LEN_AW-1:0] acc_raddr;
  logic [ACC_W-1:0]  acc_wdata, acc_rdata;

  dme_ram #(.WIDTH(16), .DEPTH(LEN_MAX)) u_staging (
    .clk(clk), .we(stg_we), .waddr(in_ei), .wdata(in_s),
    .raddr(stg_raddr), .rdata(stg_rdata)
  );

  dme_ram #(.WIDTH(16), .DEPTH(SDEPTH)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  dme_ram #(.WIDTH(ACC_W), .DEPTH(LEN_MAX)) u_acc (
    .clk(clk), .we(acc_we), .waddr(k2), .wdata(acc_wdata),
    .raddr(acc_raddr), .rdata(acc_rdata)
  );

  // item decode
  mode_t in_mode;
  logic  mode_chg, item_err, err_now;
  always_comb begin
    unique case (in_func)
      FUNC_LOAD: in_mode = MODE_LOAD;
      FUNC_FWD:  in_mode = MODE_FWD;
      FUNC_ADJ:  in_mode = MODE_ADJ;
      default:   in_mode = MODE_IDLE;
    endcase
    unique case (in_func)
      FUNC_LOAD: item_err = ({1'b0, in_ai} >= na) || ({1'b0, in_ei} >= len);
      FUNC_FWD:  item_err = ({1'b0, in_ai} >= na);
      FUNC_ADJ:  item_err = ({1'b0, in_ei} >= len);
      default:   item_err = 1'b0;
    endcase
    mode_chg = (in_func != FUNC_NONE) && (run_mode != MODE_IDLE) && (run_mode != in_mode);
    err_now  = (err && !mode_chg) || item_err;
  end

  // pipeline and helper values
  logic              out_free;
  logic [15:0]       stg_val, mag;
  logic [ACC_W:0]    acc_sum;
  logic [ACC_W-1:0]  acc_old, sq_t;
  logic [NORM_W:0]   trial;
  logic [16:0]       qm;
  logic [15:0]       qval;
  logic              mac_done, emit_issue;

  assign out_free = !oval || m_axis_tready;
  assign stg_val  = smask[e[LEN_AW-1:0]] ? stg_rdata : 16'd0;
  assign mag      = stg_val[15] ? 16'(-stg_val) : stg_val;
  assign acc_old  = accv[k2] ? acc_rdata : '0;
  assign acc_sum  = {acc_old[ACC_W-1], acc_old} + (ACC_W+1)'(prod);
  assign acc_wdata = (acc_sum[ACC_W] != acc_sum[ACC_W-1]) ?
                     (acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}}) :
                     acc_sum[ACC_W-1:0];
  assign sq_t     = root + bit_b;
  assign trial    = {drem, num[NUM_W-1]};
  assign qm       = (quo > NUM_W'(32768)) ? 17'd32768 : quo[16:0];
  assign qval     = !do_div ? sval :
                    neg ? 16'(-qm) :
                    (qm == 17'd32768) ? 16'h7fff : qm[15:0];
  assign mac_done   = (k == cnt) && !v1 && !v2;
  assign emit_issue = (k < cnt) && !pend && out_free;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_func)
            FUNC_LOAD: if (s_axis_tlast) state_next = err_now ? ST_RESULT : ST_SQ_RD;
            FUNC_FWD, FUNC_ADJ: begin
              if (!item_err) state_next = ST_MAC;
              else if (s_axis_tlast) state_next = ST_EMIT;
            end
            default: ;
          endcase
        end
      end
      ST_SQ_RD:  state_next = ST_SQ_MUL;
      ST_SQ_MUL: state_next = ST_SQ_ADD;
      ST_SQ_ADD: state_next = (e + 7'd1 == len) ? ST_SQRT : ST_SQ_RD;
      ST_SQRT:   if (bit_b[0]) state_next = ST_CHECK;
      ST_CHECK:  state_next = (sum == '0) ? ST_RESULT : ST_NRM_RD;
      ST_NRM_RD: state_next = ST_NRM_LD;
      ST_NRM_LD: state_next = do_div ? ST_DIV : ST_NRM_WR;
      ST_DIV:    if (dcnt == 5'(NUM_W - 1)) state_next = ST_NRM_WR;
      ST_NRM_WR: state_next = (e + 7'd1 == len) ? ST_RESULT : ST_NRM_RD;
      ST_RESULT: if (out_free) state_next = ST_IDLE;
      ST_MAC:    if (mac_done) state_next = last_r ? ST_EMIT : ST_IDLE;
      ST_EMIT:   if ((k == cnt) && !pend) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // RAM controls
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    stg_we    = in_acc && (in_func == FUNC_LOAD) && !item_err;
    stg_raddr = e[LEN_AW-1:0];
    st_we     = (state == ST_NRM_WR);
    st_waddr  = {AW'(ai_r), e[LEN_AW-1:0]};
    st_wdata  = qval;
    st_raddr  = fwd_r ? {AW'(ai_r), k[LEN_AW-1:0]} : {AW'(k), ei_r};
    acc_we    = (state == ST_MAC) && v2;
    acc_raddr = (state == ST_EMIT) ? k[LEN_AW-1:0] : k1;
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      run_mode <= MODE_IDLE;
      err      <= 1'b0;
      smask    <= '0;
      accv     <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      pend     <= 1'b0;
      oval     <= 1'b0;
    end else begin
      state <= state_next;
      if (oval && m_axis_tready) oval <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_acc && (in_func != FUNC_NONE)) begin
            if (mode_chg) begin
              smask <= '0;
              accv  <= '0;
            end
            run_mode <= in_mode;
            err      <= err_now;
            ai_r     <= in_ai;
            ei_r     <= in_ei;
            samp     <= in_s;
            last_r   <= s_axis_tlast;
            fwd_r    <= (in_func == FUNC_FWD);
            cnt      <= (in_func == FUNC_FWD) ? len : {1'b0, na};
            k        <= 7'd0;
            e        <= 7'd0;
            sum      <= '0;
            v1       <= 1'b0;
            v2       <= 1'b0;
            pend     <= 1'b0;
            if (stg_we) begin
              if (mode_chg) smask <= LEN_MAX'(1) << in_ei;
              else smask[in_ei] <= 1'b1;
            end
          end
        end
        ST_SQ_MUL: sq <= 32'(mag) * 32'(mag);
        ST_SQ_ADD: begin
          sum <= sum + ACC_W'(sq);
          if (e + 7'd1 == len) begin
            e      <= 7'd0;
            sq_rem <= sum + ACC_W'(sq);
            root   <= '0;
            bit_b  <= ACC_W'(1) << 38;
          end else begin
            e <= e + 7'd1;
          end
        end
        ST_SQRT: begin
          // one result bit per cycle
          if (sq_rem >= sq_t) begin
            sq_rem <= sq_rem - sq_t;
            root   <= (root >> 1) + bit_b;
          end else begin
            root <= root >> 1;
          end
          bit_b <= bit_b >> 2;
        end
        ST_CHECK: begin
          norm   <= root[NORM_W-1:0];
          do_div <= !((root >= ACC_W'(32767)) && (root <= ACC_W'(32769)));
        end
        ST_NRM_LD: begin
          sval <= stg_val;
          neg  <= stg_val[15];
          num  <= {mag, FRAC_BITS'(0)} + NUM_W'(norm >> 1);
          drem <= '0;
          quo  <= '0;
          dcnt <= '0;
        end
        ST_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (trial >= {1'b0, norm}) begin
            drem <= NORM_W'(trial - {1'b0, norm});
            quo  <= {quo[NUM_W-2:0], 1'b1};
          end else begin
            drem <= trial[NORM_W-1:0];
            quo  <= {quo[NUM_W-2:0], 1'b0};
          end
          num  <= num << 1;
          dcnt <= dcnt + 5'd1;
        end
        ST_NRM_WR: e <= e + 7'd1;
        ST_RESULT: begin
          if (out_free) begin
            oval     <= 1'b1;
            o_index  <= {1'b0, ai_r};
            o_value  <= '0;
            o_last   <= 1'b1;
            o_status <= err ? STAT_RANGE : ((sum == '0) ? STAT_ZERO : STAT_OK);
            run_mode <= MODE_IDLE;
            err      <= 1'b0;
            smask    <= '0;
            accv     <= '0;
          end
        end
        ST_MAC: begin
          // read store, multiply, accumulate
          v1 <= (k < cnt);
          if (k < cnt) begin
            k  <= k + 7'd1;
            k1 <= k[LEN_AW-1:0];
          end
          v2 <= v1;
          k2 <= k1;
          if (v1) prod <= $signed(st_rdata) * $signed(samp);
          if (v2) accv[k2] <= 1'b1;
          if (mac_done) k <= 7'd0;
        end
        ST_EMIT: begin
          if (emit_issue) begin
            pend <= 1'b1;
            ke   <= k[LEN_AW-1:0];
            k    <= k + 7'd1;
          end
          if (pend) begin
            pend     <= 1'b0;
            oval     <= 1'b1;
            o_index  <= ke;
            o_value  <= accv[ke] ? acc_rdata : '0;
            o_last   <= ({1'b0, ke} + 7'd1 == cnt);
            o_status <= err ? STAT_RANGE : STAT_OK;
          end
          if ((k == cnt) && !pend) begin
            run_mode <= MODE_IDLE;
            err      <= 1'b0;
            smask    <= '0;
            accv     <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  assign m_axis_tvalid = oval;
  assign m_axis_tdata  = {2'b00, o_value, o_index};
  assign m_axis_tuser  = o_status;
  assign m_axis_tlast  = o_last;

endmodule

// ===== src/dme_ram.sv =====
`timescale 1ns / 1ps
module dme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
